// ===== rtl/heightmap_bilinear_sampler_core_defines.svh =====
// ---------------------------------------------------------------------------
// Heightmap sampler assertion macros
// Shared assertion helpers for the heightmap bilinear sampler RTL.
// ---------------------------------------------------------------------------
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_CORE_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_CORE_DEFINES_SVH
`ifndef SYNTH
`define HBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define HBS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/hbs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heightmap sampler package
// Types, codes and constants shared by the heightmap sampler modules.
// ---------------------------------------------------------------------------
package hbs_pkg;

    localparam int GRID_DIM_DEF = 256;
    localparam int STORE_DEPTH  = 65536;
    localparam int ADDR_W       = 16;
    localparam int HEIGHT_W     = 16;
    localparam int DIM_W        = 9;
    localparam int CELL_W       = 16;
    localparam int WORLD_W      = 20;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 2'd2;

    localparam logic [DIM_W-1:0]  DIM_RESET  = 9'd256;
    localparam logic [CELL_W-1:0] CELL_RESET = 16'd256;

    typedef struct packed {
        logic                       command;
        logic [ADDR_W-1:0]          entry_index;
        logic signed [HEIGHT_W-1:0] entry_height;
        logic signed [WORLD_W-1:0]  world_x;
        logic signed [WORLD_W-1:0]  world_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sampled_height;
        logic               inside_res;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]  grid_columns;
        logic [DIM_W-1:0]  grid_rows;
        logic [CELL_W-1:0] cell_size;
    } cfg_t;

    typedef struct packed {
        logic                       is_query;
        logic [ADDR_W-1:0]          addr;
        logic signed [HEIGHT_W-1:0] height;
        logic signed [WORLD_W-1:0]  wx;
        logic signed [WORLD_W-1:0]  wz;
    } q_entry_t;

endpackage

// ===== rtl/heightmap_bilinear_sampler_core.sv =====
`timescale 1ns / 1ps
// A write transfer is written to the height store as it leaves the two-entry queue.
// A query passes from the queue to the result register: each in-grid sample runs
// the serial dividers, then the corner reads and MACs; an outside one skips them.
// Flat gives a fixed normal, else a square root and a divide per unsaturated component.
// One item is in the back end at a time; a finished query waits for the output slot.
// Reset is synchronous: grid 256 x 256, cell size 256, queue and output empty.
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler core
// Top level: configuration registers, front-end queue and sampling back end.
// ---------------------------------------------------------------------------
module heightmap_bilinear_sampler_core #(
    parameter int GRID_DIM = hbs_pkg::GRID_DIM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  hbs_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output hbs_pkg::out_item_t              m_data,
    input  logic                            cfg_wr_en,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import hbs_pkg::*;

    cfg_t     cfg_reg;
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_columns <= DIM_RESET;
            cfg_reg.grid_rows    <= DIM_RESET;
            cfg_reg.cell_size    <= CELL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GRID_COLUMNS: cfg_reg.grid_columns <= cfg_wdata[DIM_W-1:0];
                REG_GRID_ROWS:    cfg_reg.grid_rows    <= cfg_wdata[DIM_W-1:0];
                REG_CELL_SIZE:    cfg_reg.cell_size    <= cfg_wdata[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    hbs_queue u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop)
    );

    hbs_engine #(.GRID_DIM(GRID_DIM)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .q_valid(q_valid),
        .q_entry(q_entry), .q_pop(q_pop), .m_valid(m_valid), .m_ready(m_ready),
        .m_data(m_data)
    );
endmodule

// ===== rtl/hbs_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/hbs_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sampler front end
// Accepts input transfers, decodes them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module hbs_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hbs_pkg::in_item_t s_data,
    output logic              q_valid,
    output hbs_pkg::q_entry_t q_entry,
    input  logic              q_pop
);
    import hbs_pkg::*;

    q_entry_t    slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    q_entry_t    dec;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        dec.is_query = (s_data.command == CMD_QUERY);
        dec.addr     = s_data.entry_index;
        dec.height   = s_data.entry_height;
        dec.wx       = s_data.world_x;
        dec.wz       = s_data.world_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= dec;
                wr_ptr_reg           <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

// ===== rtl/hbs_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sampler divider
// Restoring divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
module hbs_div #(
    parameter int DIVIDEND_W = 42,
    parameter int DIVISOR_W  = 26,
    parameter int QUOT_W     = 25
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [QUOT_W-1:0]     quotient
);
    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [QUOT_W-1:0]    quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 ge;

    assign trial    = {rem_reg, quo_reg[QUOT_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            rem_reg <= DIVISOR_W'(dividend >> QUOT_W);
            quo_reg <= dividend[QUOT_W-1:0];
            dvs_reg <= divisor;
            cnt_reg <= CNT_W'(QUOT_W);
        end else if (busy) begin
            rem_reg <= ge ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[QUOT_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule

// ===== rtl/hbs_engine.sv =====
`timescale 1ns / 1ps
`include "heightmap_bilinear_sampler_core_defines.svh"
// ---------------------------------------------------------------------------
// Sampler back end
// Executes height writes and queries: five bilinear samples, normal, output.
// ---------------------------------------------------------------------------
module hbs_engine #(
    parameter int GRID_DIM = hbs_pkg::GRID_DIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  hbs_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  hbs_pkg::q_entry_t  q_entry,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output hbs_pkg::out_item_t m_data
);
    import hbs_pkg::*;

    localparam logic [DIM_W-1:0] DIM_MAX = (GRID_DIM > 511) ? 9'd511 : DIM_W'(GRID_DIM);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_PREP   = 14'b00000000000010,
        ST_SETUP  = 14'b00000000000100,
        ST_DIVW   = 14'b00000000001000,
        ST_RD     = 14'b00000000010000,
        ST_MAC    = 14'b00000000100000,
        ST_SDONE  = 14'b00000001000000,
        ST_NORM   = 14'b00000010000000,
        ST_SQ     = 14'b00000100000000,
        ST_SQINIT = 14'b00001000000000,
        ST_SQRT   = 14'b00010000000000,
        ST_USETUP = 14'b00100000000000,
        ST_UWAIT  = 14'b01000000000000,
        ST_OUT    = 14'b10000000000000
    } state_t;

    state_t              state_reg;
    logic signed [19:0]  wx_reg, wz_reg;
    logic [12:0]         d_reg;
    logic [DIM_W-1:0]    cols_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic [24:0]         colcell_reg, rowcell_reg;
    logic [25:0]         limx_reg, limz_reg;
    logic [2:0]          samp_reg;
    logic                inside_reg;
    logic [24:0]         gx_reg, gz_reg;
    logic [1:0]          corner_reg;
    logic [32:0]         weight_reg;
    logic signed [49:0]  acc_reg;
    logic signed [15:0]  h_reg, hl_reg, hr_reg, hd_reg, hu_reg;
    logic signed [16:0]  nx_reg, ny_reg, nz_reg;
    logic [35:0]         sq_reg;
    logic [1:0]          sqc_reg;
    logic [49:0]         sv_reg, sres_reg, sbit_reg;
    logic [4:0]          scnt_reg;
    logic [1:0]          comp_reg;
    logic signed [15:0]  nxo_reg, nyo_reg, nzo_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;

    logic [DIM_W-1:0]    cols_eff, rows_eff;
    logic [CELL_W-1:0]   cell_eff;
    logic [32:0]         d_prod;
    logic signed [20:0]  sx, sz;
    logic signed [26:0]  num2x, num2z;
    logic                in_x, in_z;
    logic                div_start, div1_start;
    logic [41:0]         div0_dividend, div1_dividend;
    logic [25:0]         div0_divisor, div1_divisor;
    logic                div0_busy, div1_busy;
    logic [24:0]         div0_quot, div1_quot;
    logic [DIM_W-1:0]    row_sel, col_sel;
    logic [17:0]         addr_full;
    logic [16:0]         wa, wb;
    logic [15:0]         ram_rdata;
    logic                ram_we;
    logic signed [49:0]  rnd;
    logic signed [16:0]  sq_sel;
    logic signed [33:0]  sq_prod;
    logic [49:0]         s_trial;
    logic signed [16:0]  u_sel;
    logic [16:0]         u_mag;
    logic [40:0]         u_dividend;
    logic                u_sat;
    logic [14:0]         u_q;
    logic signed [15:0]  u_val;

    assign cols_eff = (cfg.grid_columns < 9'd2) ? 9'd2 :
                      (cfg.grid_columns > DIM_MAX) ? DIM_MAX : cfg.grid_columns;
    assign rows_eff = (cfg.grid_rows < 9'd2) ? 9'd2 :
                      (cfg.grid_rows > DIM_MAX) ? DIM_MAX : cfg.grid_rows;
    assign cell_eff = (cfg.cell_size == '0) ? 16'd1 : cfg.cell_size;
    assign d_prod   = ({1'b0, cell_eff} + 17'd5) * 16'd52429;

    always_comb begin
        sx = {wx_reg[19], wx_reg};
        sz = {wz_reg[19], wz_reg};
        unique case (samp_reg)
            3'd1:    sx = sx - $signed({8'b0, d_reg});
            3'd2:    sx = sx + $signed({8'b0, d_reg});
            3'd3:    sz = sz - $signed({8'b0, d_reg});
            3'd4:    sz = sz + $signed({8'b0, d_reg});
            default: ;
        endcase
    end

    assign num2x = {{5{sx[20]}}, sx, 1'b0} + $signed({2'b0, colcell_reg});
    assign num2z = {{5{sz[20]}}, sz, 1'b0} + $signed({2'b0, rowcell_reg});
    assign in_x  = !num2x[26] && (num2x[25:0] < limx_reg);
    assign in_z  = !num2z[26] && (num2z[25:0] < limz_reg);

    assign u_sel      = (comp_reg == 2'd0) ? nx_reg : (comp_reg == 2'd1) ? ny_reg : nz_reg;
    assign u_mag      = u_sel[16] ? 17'(-u_sel) : u_sel;
    assign u_dividend = {1'b0, u_mag, 23'b0} + {16'b0, sres_reg[24:0]};
    assign u_sat      = (u_dividend >= {sres_reg[24:0], 16'b0});
    assign u_q        = (state_reg == ST_UWAIT && div0_quot <= 25'd16384) ?
                        div0_quot[14:0] : 15'd16384;
    assign u_val      = u_sel[16] ? -$signed({1'b0, u_q}) : $signed({1'b0, u_q});

    assign div_start     = (state_reg == ST_SETUP && in_x && in_z) ||
                           (state_reg == ST_USETUP && !u_sat);
    assign div1_start    = (state_reg == ST_SETUP && in_x && in_z);
    assign div0_dividend = (state_reg == ST_USETUP) ? {1'b0, u_dividend} :
                           {num2x[25:0], 16'b0};
    assign div0_divisor  = (state_reg == ST_USETUP) ? {sres_reg[24:0], 1'b0} :
                           {9'b0, cell_reg, 1'b0};
    assign div1_dividend = {num2z[25:0], 16'b0};
    assign div1_divisor  = {9'b0, cell_reg, 1'b0};

    hbs_div #(.DIVIDEND_W(42), .DIVISOR_W(26), .QUOT_W(25)) u_div0 (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div0_dividend),
        .divisor(div0_divisor), .busy(div0_busy), .quotient(div0_quot)
    );

    hbs_div #(.DIVIDEND_W(42), .DIVISOR_W(26), .QUOT_W(25)) u_div1 (
        .aclk(aclk), .aresetn(aresetn), .start(div1_start), .dividend(div1_dividend),
        .divisor(div1_divisor), .busy(div1_busy), .quotient(div1_quot)
    );

    assign col_sel   = gx_reg[24:16] + DIM_W'(corner_reg[0]);
    assign row_sel   = gz_reg[24:16] + DIM_W'(corner_reg[1]);
    assign addr_full = row_sel * cols_reg + {9'b0, col_sel};
    assign wa        = corner_reg[0] ? {1'b0, gx_reg[15:0]} :
                       17'h10000 - {1'b0, gx_reg[15:0]};
    assign wb        = corner_reg[1] ? {1'b0, gz_reg[15:0]} :
                       17'h10000 - {1'b0, gz_reg[15:0]};
    assign ram_we    = (state_reg == ST_IDLE) && q_valid && !q_entry.is_query;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    hbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(STORE_DEPTH)) u_store (
        .aclk(aclk), .we(ram_we), .waddr(q_entry.addr), .wdata(q_entry.height),
        .raddr(addr_full[ADDR_W-1:0]), .rdata(ram_rdata)
    );

    assign rnd     = acc_reg + 50'sd2147483648;
    assign sq_sel  = (sqc_reg == 2'd0) ? nx_reg : (sqc_reg == 2'd1) ? ny_reg : nz_reg;
    assign sq_prod = sq_sel * sq_sel;
    assign s_trial = sres_reg + sbit_reg;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready && state_reg != ST_OUT) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid && q_entry.is_query) begin
                        wx_reg    <= q_entry.wx;
                        wz_reg    <= q_entry.wz;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    d_reg       <= d_prod[31:19];
                    cols_reg    <= cols_eff;
                    cell_reg    <= cell_eff;
                    colcell_reg <= cols_eff * cell_eff;
                    rowcell_reg <= rows_eff * cell_eff;
                    limx_reg    <= (cols_eff - 9'd1) * {cell_eff, 1'b0};
                    limz_reg    <= (rows_eff - 9'd1) * {cell_eff, 1'b0};
                    samp_reg    <= 3'd0;
                    state_reg   <= ST_SETUP;
                end
                ST_SETUP: begin
                    acc_reg <= '0;
                    if (samp_reg == 3'd0) begin
                        inside_reg <= in_x && in_z;
                    end
                    state_reg <= (in_x && in_z) ? ST_DIVW : ST_SDONE;
                end
                ST_DIVW: begin
                    if (!div0_busy && !div1_busy) begin
                        gx_reg     <= div0_quot;
                        gz_reg     <= div1_quot;
                        corner_reg <= 2'd0;
                        state_reg  <= ST_RD;
                    end
                end
                ST_RD: begin
                    weight_reg <= 33'(wa * wb);
                    state_reg  <= ST_MAC;
                end
                ST_MAC: begin
                    acc_reg    <= acc_reg +
                                  50'($signed(ram_rdata) * $signed({1'b0, weight_reg}));
                    corner_reg <= corner_reg + 2'd1;
                    state_reg  <= (corner_reg == 2'd3) ? ST_SDONE : ST_RD;
                end
                ST_SDONE: begin
                    unique case (samp_reg)
                        3'd0:    h_reg  <= rnd[47:32];
                        3'd1:    hl_reg <= rnd[47:32];
                        3'd2:    hr_reg <= rnd[47:32];
                        3'd3:    hd_reg <= rnd[47:32];
                        default: hu_reg <= rnd[47:32];
                    endcase
                    samp_reg  <= samp_reg + 3'd1;
                    state_reg <= (samp_reg == 3'd4) ? ST_NORM : ST_SETUP;
                end
                ST_NORM: begin
                    nx_reg    <= 17'(hl_reg) - 17'(hr_reg);
                    nz_reg    <= 17'(hd_reg) - 17'(hu_reg);
                    ny_reg    <= $signed({3'b0, d_reg, 1'b0});
                    sq_reg    <= '0;
                    sqc_reg   <= 2'd0;
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    sq_reg    <= sq_reg + {2'b0, sq_prod[33:0]};
                    sqc_reg   <= sqc_reg + 2'd1;
                    state_reg <= (sqc_reg == 2'd2) ? ST_SQINIT : ST_SQ;
                end
                ST_SQINIT: begin
                    if (sq_reg == '0) begin
                        nxo_reg   <= '0;
                        nyo_reg   <= 16'sd16384;
                        nzo_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        sv_reg    <= {sq_reg[33:0], 16'b0};
                        sres_reg  <= '0;
                        sbit_reg  <= 50'd1 << 48;
                        scnt_reg  <= 5'd25;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sv_reg >= s_trial) begin
                        sv_reg   <= sv_reg - s_trial;
                        sres_reg <= (sres_reg >> 1) + sbit_reg;
                    end else begin
                        sres_reg <= sres_reg >> 1;
                    end
                    sbit_reg <= sbit_reg >> 2;
                    scnt_reg <= scnt_reg - 5'd1;
                    if (scnt_reg == 5'd1) begin
                        comp_reg  <= 2'd0;
                        state_reg <= ST_USETUP;
                    end
                end
                ST_USETUP, ST_UWAIT: begin
                    if ((state_reg == ST_USETUP && u_sat) ||
                        (state_reg == ST_UWAIT && !div0_busy)) begin
                        unique case (comp_reg)
                            2'd0:    nxo_reg <= u_val;
                            2'd1:    nyo_reg <= u_val;
                            default: nzo_reg <= u_val;
                        endcase
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= (comp_reg == 2'd2) ? ST_OUT : ST_USETUP;
                    end else if (state_reg == ST_USETUP) begin
                        state_reg <= ST_UWAIT;
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_reg.sampled_height <= h_reg;
                        out_reg.inside_res     <= inside_reg;
                        out_reg.normal_x       <= nxo_reg;
                        out_reg.normal_y       <= nyo_reg;
                        out_reg.normal_z       <= nzo_reg;
                        out_valid_reg          <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `HBS_ASSERT(a_pop_has_entry, aclk, aresetn, q_pop |-> q_valid, "pop from an empty queue")
    `HBS_ASSERT(a_div_idle, aclk, aresetn, div_start |-> !div0_busy && !div1_busy, "div busy")
    `HBS_ASSERT(a_ny_range, aclk, aresetn, out_valid_reg |-> !out_reg.normal_y[15], "ny < 0")
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Heightmap bilinear sampler testbench
// Loads height grids, queries world positions under several grid and cell
// settings, and checks every result against an in-bench model of the
// bilinear sample and the surface normal, with random idling on both sides in most phases.
// ---------------------------------------------------------------------------
module tb_top;
    import hbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    in_item_t pending_items[$];
    out_item_t expected_samples[$];
    logic [15:0] height_mirror [0:STORE_DEPTH-1];
    bit written_entry [0:STORE_DEPTH-1];
    logic [DIM_W-1:0] columns_mirror;
    logic [DIM_W-1:0] rows_mirror;
    logic [CELL_W-1:0] cell_mirror;

    bit idling_on;
    int send_gap;
    int recv_stall;
    int error_count;
    int quiet_cycles;
    int queries_checked;
    int writes_sent;

    heightmap_bilinear_sampler_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic int clamp_dim(logic [DIM_W-1:0] v);
        if (v < 2) return 2;
        if (v > GRID_DIM_DEF) return GRID_DIM_DEF;
        return int'(v);
    endfunction

    function automatic longint eff_cell();
        return (cell_mirror == 0) ? 64'sd1 : longint'(cell_mirror);
    endfunction

    function automatic longint entry_height_at(longint row, longint col, longint cols);
        logic [15:0] addr;
        addr = 16'(row * cols + col);
        return longint'($signed(height_mirror[addr]));
    endfunction

    function automatic bit grid_coord(longint w, longint count, longint cell_sz,
                                      output longint g);
        longint num2;
        num2 = 2 * w + count * cell_sz;
        g = 0;
        if (num2 < 0) return 1'b0;
        g = (num2 <<< 16) / (2 * cell_sz);
        return (g >>> 16) < (count - 1);
    endfunction

    function automatic longint bilinear_height(longint wx, longint wz, output bit in_grid);
        longint cols, rows, cell_sz, gx, gz, x0, z0, fx, fz, one, sum;
        bit okx, okz;
        cols = clamp_dim(columns_mirror);
        rows = clamp_dim(rows_mirror);
        cell_sz = eff_cell();
        okx = grid_coord(wx, cols, cell_sz, gx);
        okz = grid_coord(wz, rows, cell_sz, gz);
        in_grid = okx && okz;
        if (!in_grid) return 0;
        x0 = gx >>> 16;
        z0 = gz >>> 16;
        fx = gx & 64'hFFFF;
        fz = gz & 64'hFFFF;
        one = 64'sd1 <<< 16;
        sum = entry_height_at(z0, x0, cols) * ((one - fx) * (one - fz))
            + entry_height_at(z0, x0 + 1, cols) * (fx * (one - fz))
            + entry_height_at(z0 + 1, x0, cols) * ((one - fx) * fz)
            + entry_height_at(z0 + 1, x0 + 1, cols) * (fx * fz);
        return (sum + (64'sd1 <<< 31)) >>> 32;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] normal_part(longint v, longint unsigned len);
        longint unsigned mag, q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q = ((mag << 23) + len) / (2 * len);
        if (q > 16384) q = 16384;
        return (v < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic out_item_t predict_sample(in_item_t it);
        out_item_t r;
        longint wx, wz, d, h, nx, ny, nz;
        longint unsigned sq, len;
        bit ins, unused;
        wx = longint'(it.world_x);
        wz = longint'(it.world_z);
        d = (eff_cell() + 5) / 10;
        h = bilinear_height(wx, wz, ins);
        nx = bilinear_height(wx - d, wz, unused) - bilinear_height(wx + d, wz, unused);
        nz = bilinear_height(wx, wz - d, unused) - bilinear_height(wx, wz + d, unused);
        ny = 2 * d;
        sq = nx * nx + ny * ny + nz * nz;
        r.sampled_height = 16'(h);
        r.inside_res = ins;
        if (sq == 0) begin
            r.normal_x = 16'sd0;
            r.normal_y = 16'sd16384;
            r.normal_z = 16'sd0;
        end else begin
            len = int_sqrt(sq << 16);
            r.normal_x = normal_part(nx, len);
            r.normal_y = normal_part(ny, len);
            r.normal_z = normal_part(nz, len);
        end
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Input side: model update on each accepted transfer, then next payload.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_data.command == CMD_WRITE) begin
                    height_mirror[s_data.entry_index] = s_data.entry_height;
                    writes_sent++;
                end else begin
                    expected_samples.insert(expected_samples.size(), predict_sample(s_data));
                end
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                    if (idling_on && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 10);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: random stall bursts and in-order comparison.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("result transfer with no query outstanding");
                    error_count++;
                end else begin
                    out_item_t e;
                    e = expected_samples.pop_front();
                    check_field("sampled_height", e.sampled_height, m_data.sampled_height);
                    check_field("inside_res", e.inside_res, m_data.inside_res);
                    check_field("normal_x", e.normal_x, m_data.normal_x);
                    check_field("normal_y", e.normal_y, m_data.normal_y);
                    check_field("normal_z", e.normal_z, m_data.normal_z);
                    queries_checked++;
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    recv_stall <= $urandom_range(1, 10);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (pending_items.size() == 0 && !s_valid
                    && expected_samples.size() == 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired: %0d results outstanding", expected_samples.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_samples.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_GRID_COLUMNS: columns_mirror = val[DIM_W-1:0];
            REG_GRID_ROWS: rows_mirror = val[DIM_W-1:0];
            default: cell_mirror = val;
        endcase
    endtask

    task automatic push_write(int idx, logic [15:0] h);
        in_item_t it;
        it.command = CMD_WRITE;
        it.entry_index = 16'(idx);
        it.entry_height = h;
        it.world_x = 20'($urandom);
        it.world_z = 20'($urandom);
        written_entry[idx] = 1'b1;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_query(longint wx, longint wz);
        in_item_t it;
        it.command = CMD_QUERY;
        it.entry_index = 16'($urandom);
        it.entry_height = 16'($urandom);
        it.world_x = 20'(wx);
        it.world_z = 20'(wz);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic longint near_grid(int count);
        longint g, w;
        g = longint'($urandom_range(0, (count + 2) * 256)) - 256 - count * 128;
        w = (g * eff_cell()) / 256 + longint'($urandom_range(0, 7)) - 4;
        if (w > 524287) w = 524287;
        if (w < -524288) w = -524288;
        return w;
    endfunction

    task automatic run_phase(int cols, int rows, int cell_sz, int n_items, bit flat);
        int ec, er;
        logic [15:0] base;
        wait_drained();
        write_reg(REG_GRID_COLUMNS, 16'(cols));
        write_reg(REG_GRID_ROWS, 16'(rows));
        write_reg(REG_CELL_SIZE, 16'(cell_sz));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ec = clamp_dim(columns_mirror);
        er = clamp_dim(rows_mirror);
        base = 16'($urandom);
        for (int i = 0; i < ec * er; i++)
            if (flat || !written_entry[i])
                push_write(i, flat ? base : 16'($urandom_range(0, 4095) - 2048));
        for (int n = 0; n < n_items; n++) begin
            case ($urandom_range(0, 9))
                0: push_write($urandom_range(0, ec * er - 1),
                              flat ? base : 16'($urandom));
                1: push_write($urandom_range(ec * er, STORE_DEPTH - 1), 16'($urandom));
                2: push_query(longint'($signed(20'($urandom))),
                              longint'($signed(20'($urandom))));
                default: push_query(near_grid(ec), near_grid(er));
            endcase
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        columns_mirror = DIM_RESET;
        rows_mirror = DIM_RESET;
        cell_mirror = CELL_RESET;
        idling_on = 1'b1;
        error_count = 0;
        queries_checked = 0;
        writes_sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Smallest grid with extreme heights and extreme world positions.
        run_phase(2, 2, 256, 0, 1'b0);
        push_write(0, 16'h8000);
        push_write(1, 16'h7FFF);
        push_write(2, 16'h7FFF);
        push_write(3, 16'h8000);
        push_write(STORE_DEPTH - 1, 16'h1234);
        push_query(0, 0);
        push_query(-256, -256);
        push_query(-257, -256);
        push_query(255, 255);
        push_query(256, 0);
        push_query(-524288, -524288);
        push_query(524287, 524287);
        push_query(-524288, 524287);
        push_query(128, -128);
        push_query(-1, 1);
        push_query(-200, 200);

        run_phase(256, 2, 1, 90, 1'b0);
        run_phase(0, 511, 65535, 90, 1'b0);
        run_phase(511, 1, 0, 90, 1'b0);
        run_phase(8, 8, 2560, 50, 1'b1);
        idling_on = 1'b0;
        run_phase(16, 12, 300, 90, 1'b0);
        idling_on = 1'b1;
        for (int p = 0; p < 4; p++)
            run_phase($urandom_range(2, 24), $urandom_range(2, 24),
                      $urandom_range(1, 4000), 90, 1'b0);
        run_phase(40, 3, 7, 80, 1'b0);
        idling_on = 1'b0;
        run_phase($urandom_range(2, 20), $urandom_range(2, 20), 256, 90, 1'b0);
        wait_drained();

        $display("Covered %0d checked queries and %0d height writes", queries_checked,
                 writes_sent);
        $display("over grids from 2 to 256 samples per side and cell sizes 0 to 65535.");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
